// File: src/dct_pkg.sv
`default_nettype none

package dct_pkg;

    // Chain mode is built in; at 0 chain starts halt like normal mode.
    localparam logic CHAIN_CAPABLE = 1'b1;

    localparam int START_BIT  = 8;
    localparam int IRQ_BIT    = 31;
    localparam int QW_SHIFT   = 4;      // 16 bytes per quadword

    typedef enum logic {
        OP_REG_WRITE = 1'b0,
        OP_TAG_WORD  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_CONTROL  = 2'd0,
        REG_MEM_ADDR = 2'd1,
        REG_COUNT    = 2'd2,
        REG_TAG_ADDR = 2'd3
    } reg_sel_t;

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_CHAIN      = 2'd1,
        MODE_INTERLEAVE = 2'd2,
        MODE_RESERVED   = 2'd3
    } mode_t;

    localparam logic [2:0] ID_CNTS = 3'd0;
    localparam logic [2:0] ID_CNT  = 3'd1;
    localparam logic [2:0] ID_END  = 3'd7;

    typedef struct packed {
        op_t         operation;
        reg_sel_t    reg_select;
        logic [31:0] write_data;
        logic [31:0] tag_word;
    } item_t;

    typedef struct packed {
        logic        xfer_valid;
        logic [31:0] xfer_addr;
        logic [15:0] xfer_qwc;
        logic        fetch_valid;
        logic [31:0] fetch_addr;
        logic        irq;
        logic        running;
        logic [31:0] stall_addr;
    } result_t;

    typedef struct packed {
        logic [31:0] control;
        logic [31:0] mem_addr;
        logic [15:0] quad_count;
        logic [31:0] tag_addr;
        logic [31:0] stall_address;
        logic        busy;
    } chan_state_t;

endpackage

`default_nettype wire

// File: src/dct_engine.sv
`default_nettype none

module dct_engine
    import dct_pkg::*;
(
    input  var chan_state_t state,
    input  var item_t       item,
    output chan_state_t     state_next,
    output result_t         result_next
);

    logic [15:0] tag_qwc;
    logic [31:0] body_addr;
    logic [31:0] next_tag_addr;
    logic [2:0]  tag_id;
    logic        tag_ok;
    logic        tag_taken;

    assign tag_qwc       = item.tag_word[15:0];
    assign tag_id        = item.tag_word[30:28];
    assign body_addr     = state.tag_addr + 32'd16;
    assign next_tag_addr = body_addr + {12'd0, tag_qwc, {QW_SHIFT{1'b0}}};
    assign tag_taken     = state.busy && CHAIN_CAPABLE
                           && (mode_t'(state.control[3:2]) == MODE_CHAIN);

    always_comb
    begin
        state_next  = state;
        result_next = '0;
        tag_ok      = 1'b0;

        unique case (item.operation)
            OP_REG_WRITE:
            begin
                unique case (item.reg_select)
                    REG_CONTROL:
                    begin
                        state_next.control = item.write_data;
                        if (item.write_data[START_BIT])
                        begin
                            if (!state.busy)
                            begin
                                state_next.busy = 1'b1;
                                unique case (mode_t'(item.write_data[3:2]))
                                    MODE_NORMAL, MODE_INTERLEAVE:
                                    begin
                                        state_next.busy = 1'b0;
                                        state_next.control[START_BIT] = 1'b0;
                                    end
                                    MODE_CHAIN:
                                    begin
                                        if (CHAIN_CAPABLE)
                                        begin
                                            // initial transfer goes out even at zero count
                                            result_next.xfer_valid  = 1'b1;
                                            result_next.xfer_addr   = state.mem_addr;
                                            result_next.xfer_qwc    = state.quad_count;
                                            result_next.fetch_valid = 1'b1;
                                            result_next.fetch_addr  = state.tag_addr;
                                        end
                                        else
                                        begin
                                            state_next.busy = 1'b0;
                                            state_next.control[START_BIT] = 1'b0;
                                        end
                                    end
                                    default:
                                    begin
                                        // reserved mode: sits busy until stopped
                                    end
                                endcase
                            end
                        end
                        else if (state.busy)
                        begin
                            state_next.busy = 1'b0;
                            state_next.control[START_BIT] = 1'b0;
                        end
                    end
                    REG_MEM_ADDR: state_next.mem_addr   = item.write_data;
                    REG_COUNT:    state_next.quad_count = item.write_data[15:0];
                    default:      state_next.tag_addr   = item.write_data;
                endcase
            end
            default:
            begin
                if (tag_taken)
                begin
                    state_next.quad_count = tag_qwc;
                    state_next.control    = {item.tag_word[31:16], state.control[15:0]};
                    tag_ok                = 1'b1;
                    case (tag_id)
                        ID_CNTS, ID_CNT:
                        begin
                            state_next.mem_addr = body_addr;
                            state_next.tag_addr = next_tag_addr;
                            if (tag_id == ID_CNTS)
                            begin
                                state_next.stall_address = next_tag_addr;
                            end
                        end
                        ID_END:
                        begin
                            state_next.mem_addr = body_addr;
                            state_next.busy = 1'b0;
                            state_next.control[START_BIT] = 1'b0;
                        end
                        default:
                        begin
                            // unknown id aborts the chain
                            state_next.busy = 1'b0;
                            state_next.control[START_BIT] = 1'b0;
                            tag_ok = 1'b0;
                        end
                    endcase
                    if (tag_ok)
                    begin
                        if (tag_qwc != 16'd0)
                        begin
                            result_next.xfer_valid = 1'b1;
                            result_next.xfer_addr  = state_next.mem_addr;
                            result_next.xfer_qwc   = tag_qwc;
                        end
                        result_next.irq = item.tag_word[IRQ_BIT];
                        if (state_next.control[START_BIT])
                        begin
                            result_next.fetch_valid = 1'b1;
                            result_next.fetch_addr  = state_next.tag_addr;
                        end
                    end
                end
            end
        endcase

        result_next.running    = state_next.busy;
        result_next.stall_addr = state_next.stall_address;
    end

endmodule

`default_nettype wire

// File: src/dma_chain_tag_channel.sv
`default_nettype none

// Channel    Signals                                  Moves
// item       item_valid / item_ready / item           register write or tag word
// result     result_valid / result_ready / result     transfer, fetch, irq, status
//
// One item per cycle while results are taken; its result shows in the cycle after the transfer.
// The channel registers and the result register update on the same edge,
// so back-to-back items see each other's state with no bubble.
// Reset clears every channel register and drops result_valid.
// A stalled result holds; item_ready stays high while the result is taken.

module dma_chain_tag_channel
    import dct_pkg::*;
(
    input  var logic    clk,
    input  var logic    rst_n,
    input  var logic    item_valid,
    output logic        item_ready,
    input  var item_t   item,
    output logic        result_valid,
    input  var logic    result_ready,
    output result_t     result
);

    chan_state_t state_reg;
    chan_state_t state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        result_valid_reg;
    logic        accept;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    dct_engine u_engine (
        .state       (state_reg),
        .item        (item),
        .state_next  (state_next),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: src/dct_checker.sv
`default_nettype none

module dct_checker
    import dct_pkg::*;
(
    input var logic    clk,
    input var logic    rst_n,
    input var logic    item_valid,
    input var logic    item_ready,
    input var item_t   item,
    input var logic    result_valid,
    input var logic    result_ready,
    input var result_t result
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_xfer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.xfer_valid |->
            result.xfer_addr == 32'd0 && result.xfer_qwc == 16'd0)
        else $error("transfer fields set without a transfer");

    a_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fetch_valid |-> result.fetch_addr == 32'd0)
        else $error("fetch address set without a fetch");

    a_fetch_running: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fetch_valid |-> result.running)
        else $error("tag fetch requested by an idle channel");

    // plain address or count writes never start anything
    a_data_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.operation == OP_REG_WRITE
            && item.reg_select != REG_CONTROL
        |=> result_valid && !result.xfer_valid && !result.fetch_valid && !result.irq)
        else $error("data register write produced a request");

endmodule

bind dma_chain_tag_channel dct_checker u_checker (.*);

`default_nettype wire

// File: tb/chan_result_checker.sv
module chan_result_checker
    import dct_pkg::*;
(
    input  var logic    clk,
    input  var logic    rst_n,
    input  var logic    item_valid,
    input  var logic    item_ready,
    input  var item_t   item,
    input  var logic    result_valid,
    input  var logic    result_ready,
    input  var result_t result,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the channel registers
    logic [31:0] ch_control;
    logic [31:0] ch_mem_addr;
    logic [15:0] ch_qwc;
    logic [31:0] ch_tag_addr;
    logic [31:0] ch_stall_addr;
    logic        ch_busy;

    result_t predicted_results[$];
    int      results_seen;

    function automatic void stop_channel();
        ch_busy = 1'b0;
        ch_control[START_BIT] = 1'b0;
    endfunction

    function automatic result_t next_channel_result(item_t it);
        result_t    r;
        logic [2:0] tag_id;
        logic       tag_ok;
        r = '0;
        if (it.operation == OP_REG_WRITE)
        begin
            case (it.reg_select)
                REG_CONTROL:
                begin
                    ch_control = it.write_data;
                    if (ch_control[START_BIT])
                    begin
                        // start while busy only stores the word
                        if (!ch_busy)
                        begin
                            ch_busy = 1'b1;
                            case (ch_control[3:2])
                                MODE_NORMAL, MODE_INTERLEAVE: stop_channel();
                                MODE_CHAIN:
                                begin
                                    if (CHAIN_CAPABLE)
                                    begin
                                        r.xfer_valid  = 1'b1;
                                        r.xfer_addr   = ch_mem_addr;
                                        r.xfer_qwc    = ch_qwc;
                                        r.fetch_valid = 1'b1;
                                        r.fetch_addr  = ch_tag_addr;
                                    end
                                    else
                                        stop_channel();
                                end
                                default: ;  // reserved mode just sits busy
                            endcase
                        end
                    end
                    else if (ch_busy)
                        stop_channel();
                end
                REG_MEM_ADDR: ch_mem_addr = it.write_data;
                REG_COUNT:    ch_qwc = it.write_data[15:0];
                default:      ch_tag_addr = it.write_data;
            endcase
        end
        else if (ch_busy && CHAIN_CAPABLE && ch_control[3:2] == MODE_CHAIN)
        begin
            tag_id = it.tag_word[30:28];
            tag_ok = 1'b1;
            ch_qwc = it.tag_word[15:0];
            ch_control[31:16] = it.tag_word[31:16];
            case (tag_id)
                ID_CNTS, ID_CNT:
                begin
                    ch_mem_addr = ch_tag_addr + 32'd16;
                    ch_tag_addr = ch_tag_addr + 32'd16 + ({16'd0, ch_qwc} << QW_SHIFT);
                    if (tag_id == ID_CNTS)
                        ch_stall_addr = ch_tag_addr;
                end
                ID_END:
                begin
                    ch_mem_addr = ch_tag_addr + 32'd16;
                    stop_channel();
                end
                default:
                begin
                    stop_channel();
                    tag_ok = 1'b0;
                end
            endcase
            if (tag_ok)
            begin
                if (ch_qwc != 16'd0)
                begin
                    r.xfer_valid = 1'b1;
                    r.xfer_addr  = ch_mem_addr;
                    r.xfer_qwc   = ch_qwc;
                end
                r.irq = it.tag_word[IRQ_BIT];
                if (ch_control[START_BIT])
                begin
                    r.fetch_valid = 1'b1;
                    r.fetch_addr  = ch_tag_addr;
                end
            end
        end
        r.running    = ch_busy;
        r.stall_addr = ch_stall_addr;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: result %0d %s: got %h, want %h", $realtime, results_seen, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            ch_control    = '0;
            ch_mem_addr   = '0;
            ch_qwc        = '0;
            ch_tag_addr   = '0;
            ch_stall_addr = '0;
            ch_busy       = 1'b0;
            predicted_results.delete();
            results_seen  = 0;
            pending      <= 0;
        end
        else
        begin
            // results leave before this edge's item is predicted
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("unexpected transfer", 32'(result.running), 32'hx);
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.xfer_valid !== want.xfer_valid)
                        report_mismatch("xfer_valid", 32'(result.xfer_valid),
                                        32'(want.xfer_valid));
                    if (result.xfer_addr !== want.xfer_addr)
                        report_mismatch("xfer_addr", result.xfer_addr, want.xfer_addr);
                    if (result.xfer_qwc !== want.xfer_qwc)
                        report_mismatch("xfer_qwc", 32'(result.xfer_qwc), 32'(want.xfer_qwc));
                    if (result.fetch_valid !== want.fetch_valid)
                        report_mismatch("fetch_valid", 32'(result.fetch_valid),
                                        32'(want.fetch_valid));
                    if (result.fetch_addr !== want.fetch_addr)
                        report_mismatch("fetch_addr", result.fetch_addr, want.fetch_addr);
                    if (result.irq !== want.irq)
                        report_mismatch("irq", 32'(result.irq), 32'(want.irq));
                    if (result.running !== want.running)
                        report_mismatch("running", 32'(result.running), 32'(want.running));
                    if (result.stall_addr !== want.stall_addr)
                        report_mismatch("stall_addr", result.stall_addr, want.stall_addr);
                end
                results_seen++;
            end
            if (item_valid && item_ready)
                predicted_results.push_back(next_channel_result(item));
            pending <= predicted_results.size();
        end
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dct_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] ID_UNKNOWN = 3'd3;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      failures;
    int      pending;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      items_sent;

    dma_chain_tag_channel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    chan_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ends the run if neither channel moves for too long
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("dma_chain_tag_channel regression: fail");
        $finish;
    end

    function automatic logic [31:0] make_control(mode_t mode, logic start, logic [31:0] rest);
        logic [31:0] w;
        w = rest;
        w[START_BIT] = start;
        w[3:2] = mode;
        return w;
    endfunction

    function automatic logic [31:0] make_tag(logic [2:0] id, logic irq, logic [15:0] qwc);
        logic [31:0] w;
        w = $urandom();
        w[IRQ_BIT] = irq;
        w[30:28] = id;
        w[15:0] = qwc;
        return w;
    endfunction

    function automatic logic [15:0] random_qwc();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [2:0] unknown_id();
        return 3'($urandom_range(ID_CNT + 1, ID_END - 1));
    endfunction

    task automatic push_item(item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(reg_sel_t sel, logic [31:0] data);
        item_t it;
        it.operation  = OP_REG_WRITE;
        it.reg_select = sel;
        it.write_data = data;
        it.tag_word   = $urandom();
        push_item(it);
    endtask

    task automatic send_tag(logic [31:0] tag);
        item_t it;
        it.operation  = OP_TAG_WORD;
        it.reg_select = reg_sel_t'($urandom_range(0, 3));
        it.write_data = $urandom();
        it.tag_word   = tag;
        push_item(it);
    endtask

    task automatic send_noise();
        item_t it;
        it.operation  = op_t'($urandom_range(0, 1));
        it.reg_select = reg_sel_t'($urandom_range(0, 3));
        it.write_data = $urandom();
        it.tag_word   = $urandom();
        push_item(it);
    endtask

    // chain: set up registers, start, walk one to eight tags, then end, abort, stop or leave it open
    task automatic run_chain();
        int n_tags;
        logic [31:0] tag_base;
        n_tags = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_MEM_ADDR, $urandom());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_COUNT, {16'($urandom()), random_qwc()});
        tag_base = $urandom();
        if ($urandom_range(0, 5) == 0)
            tag_base[31:12] = '1;   // near the top so the walk wraps
        write_reg(REG_TAG_ADDR, tag_base);
        write_reg(REG_CONTROL, make_control(MODE_CHAIN, 1'b1, $urandom()));
        for (int k = 0; k < n_tags; k++)
        begin
            if ($urandom_range(0, 99) < 6)
                write_reg(reg_sel_t'($urandom_range(0, 3)), $urandom());
            send_tag(make_tag($urandom_range(0, 1) ? ID_CNTS : ID_CNT,
                              1'($urandom_range(0, 1)), random_qwc()));
        end
        case ($urandom_range(0, 4))
            0, 1: send_tag(make_tag(ID_END, 1'($urandom_range(0, 1)), random_qwc()));
            2:    send_tag(make_tag(unknown_id(), 1'($urandom_range(0, 1)), random_qwc()));
            3:    write_reg(REG_CONTROL, make_control(mode_t'($urandom_range(0, 3)), 1'b0,
                                                      $urandom()));
            default: ;  // left open; next start lands on a busy channel
        endcase
    endtask

    task automatic run_phase(int upto);
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                run_chain();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        item          <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 31;
        recv_idle_pct = 76;

        send_tag(32'hFFFF_FFFF);                        // idle: ignored
        write_reg(REG_MEM_ADDR, 32'hFFFF_FFFF);
        write_reg(REG_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_TAG_ADDR, 32'hFFFF_FFF0);
        write_reg(REG_CONTROL, make_control(MODE_CHAIN, 1'b1, '0));
        send_tag(make_tag(ID_CNTS, 1'b1, 16'hFFFF));     // tag address wraps
        write_reg(REG_CONTROL, make_control(MODE_CHAIN, 1'b1, '0));  // start while busy
        send_tag(make_tag(ID_CNT, 1'b0, 16'd0));
        send_tag(make_tag(ID_END, 1'b1, 16'd5));
        write_reg(REG_COUNT, 32'd0);
        write_reg(REG_CONTROL, make_control(MODE_CHAIN, 1'b1, '0));  // zero-count transfer
        send_tag(make_tag(ID_UNKNOWN, 1'b1, 16'd7));
        write_reg(REG_CONTROL, make_control(MODE_NORMAL, 1'b1, '0));
        write_reg(REG_CONTROL, make_control(MODE_INTERLEAVE, 1'b1, '0));
        write_reg(REG_CONTROL, make_control(MODE_RESERVED, 1'b1, '0));
        send_tag(make_tag(ID_CNTS, 1'b0, 16'd1));        // reserved mode: ignored
        write_reg(REG_CONTROL, make_control(MODE_RESERVED, 1'b0, '0));
        write_reg(REG_CONTROL, make_control(MODE_CHAIN, 1'b1, '0));
        write_reg(REG_CONTROL, make_control(MODE_INTERLEAVE, 1'b1, '0));  // mode moves off chain
        send_tag(make_tag(ID_CNT, 1'b1, 16'd2));         // ignored after mode change
        write_reg(REG_CONTROL, make_control(MODE_NORMAL, 1'b0, '0));
        write_reg(REG_CONTROL, make_control(MODE_NORMAL, 1'b0, '0));
        write_reg(REG_CONTROL, make_control(MODE_RESERVED, 1'b1, '1));
        write_reg(REG_CONTROL, make_control(MODE_NORMAL, 1'b0, '0));

        run_phase(160);
        send_idle_pct = 76;
        recv_idle_pct = 31;
        run_phase(290);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(425);
        item_valid <= 1'b0;

        // pending is registered, so let it update before looking
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("dma_chain_tag_channel regression: pass");
        else
            $display("dma_chain_tag_channel regression: fail");
        $finish;
    end

endmodule

// File: sim.f
src/dct_pkg.sv
src/dct_engine.sv
src/dma_chain_tag_channel.sv
src/dct_checker.sv
tb/chan_result_checker.sv
tb/tb_top.sv
